### hw/rtl/urlpd_pkg.sv
package urlpd_pkg;

    typedef enum logic [2:0] {
        ESC_IDLE = 3'b001,
        ESC_HIGH = 3'b010,
        ESC_LOW  = 3'b100
    } esc_t;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_ENCODING = 2'd1,
        ERR_PATH     = 2'd2
    } err_t;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_DOT     = 8'h2E;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } in_t;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] out_byte;
        logic       done_res;
        logic [1:0] status;
    } out_t;

    typedef struct packed {
        esc_t       escape_phase;
        logic [3:0] high_nibble;
        logic       prev_was_dot;
        logic       emitted_any;
        err_t       error_code;
    } scan_t;

    localparam scan_t SCAN_RESET = '{
        escape_phase: ESC_IDLE,
        high_nibble:  4'd0,
        prev_was_dot: 1'b0,
        emitted_any:  1'b0,
        error_code:   ERR_NONE
    };

    // bit 4 set when c is not a hex digit, else bits 3:0 hold its value
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b0, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b0, 4'(c - 8'h41 + 8'd10)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b0, 4'(c - 8'h61 + 8'd10)};
        end
        return r;
    endfunction

endpackage

### hw/rtl/url_percent_decode_path_check_top.sv
// channel | valid     | stall     | payload
// input   | req_valid | req_stall | req (in_byte, last_byte)
// result  | rsp_valid | rsp_stall | rsp (has_byte, out_byte, done_res, status)
//
// one item per cycle while req_stall is low; an item goes to the input register and its
// result to the result register; the single decode step between the two sets that rate
// rst_n clears the valid flags and the scan state; the next byte is taken as a new uri
// an item that gives no result leaves the input register even while rsp_stall is high
// req_stall rises only when the input register holds an item with a result and rsp is full
module url_percent_decode_path_check_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  urlpd_pkg::in_t   req,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output urlpd_pkg::out_t  rsp
);
    import urlpd_pkg::*;

    logic   s1_valid_reg;
    logic   s1_valid_next;
    in_t    s1_item_reg;
    in_t    s1_item_next;
    scan_t  state_reg;
    scan_t  state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    out_t   rsp_reg;
    out_t   rsp_next;

    scan_t  step_state;
    out_t   step_res;
    logic   step_has_result;
    logic   out_free;
    logic   s1_fire;
    logic   accept;

    urlpd_step u_step (
        .cur        (state_reg),
        .item       (s1_item_reg),
        .nxt        (step_state),
        .res        (step_res),
        .has_result (step_has_result)
    );

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign s1_fire   = s1_valid_reg && (!step_has_result || out_free);
    assign req_stall = s1_valid_reg && !s1_fire;
    assign accept    = req_valid && !req_stall;

    always_comb
    begin
        s1_valid_next  = accept || (s1_valid_reg && !s1_fire);
        s1_item_next   = accept ? req : s1_item_reg;
        state_next     = s1_fire ? step_state : state_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        if (s1_fire && step_has_result)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = step_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            state_reg     <= SCAN_RESET;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            state_reg     <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_item_reg <= s1_item_next;
        rsp_reg     <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // bad encoding sticks until the last byte of the uri
    a_enc_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && !s1_item_reg.last_byte && state_reg.error_code == ERR_ENCODING
        |=> state_reg.error_code == ERR_ENCODING)
        else $error("bad encoding cleared before end of uri");

    // the last byte returns the scan state to its reset value
    a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_item_reg.last_byte |=> state_reg == SCAN_RESET)
        else $error("scan state not cleared after last byte");

    // no byte is emitted once an error is recorded
    a_no_emit_after_err: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && state_reg.error_code != ERR_NONE |=> !rsp_valid_reg || !rsp_reg.has_byte
        || !$changed(rsp_reg) && !$rose(rsp_valid_reg) && $past(rsp_valid_reg))
        else $error("byte emitted after error");

    // status is only reported on the final result
    a_status_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && !rsp_reg.done_res |-> rsp_reg.status == ERR_NONE)
        else $error("status set on a result that is not final");

    // a result that arrives in the output register came from a fired item
    a_rsp_from_fire: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid_reg |=> !rsp_valid_reg || $past(s1_fire && step_has_result))
        else $error("result appeared without a decoded item");

endmodule

### hw/rtl/urlpd_step.sv
module urlpd_step (
    input  urlpd_pkg::scan_t cur,
    input  urlpd_pkg::in_t   item,
    output urlpd_pkg::scan_t nxt,
    output urlpd_pkg::out_t  res,
    output logic             has_result
);
    import urlpd_pkg::*;

    logic [4:0] hv;
    logic       have_dec;
    logic [7:0] dec;
    logic       emit;

    assign hv = hex_digit(item.in_byte);

    always_comb
    begin
        nxt      = cur;
        have_dec = 1'b0;
        dec      = 8'd0;
        emit     = 1'b0;
        res      = '0;

        // after a bad encoding everything up to the last byte is ignored
        if (cur.error_code != ERR_ENCODING)
        begin
            unique case (cur.escape_phase)
                ESC_HIGH:
                begin
                    if (hv[4])
                    begin
                        nxt.error_code   = ERR_ENCODING;
                        nxt.escape_phase = ESC_IDLE;
                    end
                    else
                    begin
                        nxt.high_nibble  = hv[3:0];
                        nxt.escape_phase = ESC_LOW;
                    end
                end
                ESC_LOW:
                begin
                    nxt.escape_phase = ESC_IDLE;
                    if (hv[4])
                    begin
                        nxt.error_code = ERR_ENCODING;
                    end
                    else
                    begin
                        dec      = {cur.high_nibble, hv[3:0]};
                        have_dec = 1'b1;
                    end
                end
                default:
                begin
                    if (item.in_byte == CH_PERCENT)
                    begin
                        nxt.escape_phase = ESC_HIGH;
                    end
                    else if (item.in_byte == CH_PLUS)
                    begin
                        dec      = CH_SPACE;
                        have_dec = 1'b1;
                    end
                    else
                    begin
                        dec      = item.in_byte;
                        have_dec = 1'b1;
                    end
                end
            endcase
        end

        // path rules on the decoded byte
        if (have_dec && nxt.error_code == ERR_NONE)
        begin
            if (!cur.emitted_any && dec != CH_SLASH)
            begin
                nxt.error_code = ERR_PATH;
            end
            else if (dec == CH_DOT && cur.prev_was_dot)
            begin
                nxt.error_code = ERR_PATH;
            end
            else
            begin
                emit             = 1'b1;
                nxt.emitted_any  = 1'b1;
                nxt.prev_was_dot = (dec == CH_DOT);
            end
        end

        res.has_byte = emit;
        res.out_byte = emit ? dec : 8'd0;
        res.done_res = item.last_byte;

        if (item.last_byte)
        begin
            if (nxt.escape_phase != ESC_IDLE)
            begin
                nxt.error_code = ERR_ENCODING;
            end
            if (nxt.error_code == ERR_NONE && !nxt.emitted_any)
            begin
                nxt.error_code = ERR_PATH;
            end
            res.status = nxt.error_code;
            nxt        = SCAN_RESET;
        end

        has_result = emit | item.last_byte;
    end

endmodule
